@@ sv/tlut_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and control struct of the ternary lut dot product
package tlut_pkg;

	localparam int LANES_DEF     = 8;
	localparam int ACC_WIDTH_DEF = 32;

	localparam int ACT_W      = 8;
	localparam int CODE_W     = 64;
	localparam int BYTE_W     = 8;
	localparam int NIB_W      = 4;
	localparam int GROUP_W    = 9;
	localparam int COL_W      = 12;
	localparam int DOT_W      = 32;

	// nine pair codes: (a-1)*x0 + (b-1)*x1 at index 3*a + b
	localparam int PAIR_CODES = 9;
	localparam int PAIR_W     = ACT_W + 2;
	localparam int SUM_W      = PAIR_W + 1;

	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef pair_t [PAIR_CODES-1:0] pair_tab_t;

	typedef struct packed {
		logic capture;
		logic accum;
		logic clear;
	} lane_ctl_t;

endpackage

@@ sv/tlut_if.sv @@
`timescale 1ns / 1ps
// input and result channel interfaces
interface tlut_in_if;
	import tlut_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [ACT_W-1:0]    act_0;
	logic signed [ACT_W-1:0]    act_1;
	logic signed [ACT_W-1:0]    act_2;
	logic signed [ACT_W-1:0]    act_3;
	logic        [CODE_W-1:0]   weight_codes;
	logic        [GROUP_W-1:0]  column_group;
	logic                       last_step;

	modport source (output valid, act_0, act_1, act_2, act_3, weight_codes, column_group,
		last_step, input ready);
	modport sink (input valid, act_0, act_1, act_2, act_3, weight_codes, column_group,
		last_step, output ready);
	modport monitor (input valid, ready, act_0, act_1, act_2, act_3, weight_codes,
		column_group, last_step);
endinterface

interface tlut_out_if;
	import tlut_pkg::*;

	logic                     valid;
	logic                     ready;
	logic        [COL_W-1:0]  column;
	logic signed [DOT_W-1:0]  dot_sum;
	logic                     last_column;

	modport source (output valid, column, dot_sum, last_column, input ready);
	modport sink (input valid, column, dot_sum, last_column, output ready);
	modport monitor (input valid, ready, column, dot_sum, last_column);
endinterface

@@ sv/tlut_table.sv @@
`timescale 1ns / 1ps
// nine-entry pair sum table for one pair of activations
module tlut_table
	import tlut_pkg::*;
(
	input  logic signed [ACT_W-1:0] x0,
	input  logic signed [ACT_W-1:0] x1,
	output pair_tab_t               tab
);

	pair_t x0_ext;
	pair_t x1_ext;

	assign x0_ext = PAIR_W'(x0);
	assign x1_ext = PAIR_W'(x1);

	for (genvar i = 0; i < PAIR_CODES; i++) begin : g_entry
		localparam int WA = i / 3 - 1;
		localparam int WB = i % 3 - 1;
		pair_t term_a;
		pair_t term_b;

		assign term_a = (WA > 0) ? x0_ext : ((WA < 0) ? -x0_ext : '0);
		assign term_b = (WB > 0) ? x1_ext : ((WB < 0) ? -x1_ext : '0);
		assign tab[i] = term_a + term_b;
	end

endmodule

@@ sv/tlut_lane.sv @@
`timescale 1ns / 1ps
// one lane: table lookup for both nibbles, registered step sum and accumulator
module tlut_lane
	import tlut_pkg::*;
#(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lane_ctl_t             ctl,
	input  logic [BYTE_W-1:0]     code,
	input  pair_tab_t             tab01,
	input  pair_tab_t             tab23,
	output logic [ACC_WIDTH-1:0]  total
);

	logic [NIB_W-1:0]          code_lo;
	logic [NIB_W-1:0]          code_hi;
	pair_t                     pair_lo;
	pair_t                     pair_hi;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   sum_s1;
	logic [ACC_WIDTH-1:0]      acc_q;

	assign code_lo = code[NIB_W-1:0];
	assign code_hi = code[BYTE_W-1:NIB_W];

	// unused codes pick zero
	assign pair_lo = (code_lo < NIB_W'(PAIR_CODES)) ? $signed(tab01[code_lo]) : '0;
	assign pair_hi = (code_hi < NIB_W'(PAIR_CODES)) ? $signed(tab23[code_hi]) : '0;
	assign sum     = SUM_W'(pair_lo) + SUM_W'(pair_hi);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			sum_s1 <= sum;
		end
	end

	assign total = acc_q + ACC_WIDTH'(sum_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.accum) begin
			acc_q <= ctl.clear ? '0 : total;
		end
	end

endmodule

@@ sv/tlut_drain.sv @@
`timescale 1ns / 1ps
// result buffer that takes all lane totals at once and sends them one per transfer
module tlut_drain
	import tlut_pkg::*;
#(
	parameter int LANES     = LANES_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [GROUP_W-1:0]                group,
	input  logic [LANES-1:0][ACC_WIDTH-1:0]   totals,
	output logic                              free,
	tlut_out_if.source                        out_ch
);

	localparam int IDX_W    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int EXT_W    = (ACC_WIDTH > DOT_W) ? ACC_WIDTH : DOT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LANES - 1);

	logic [LANES-1:0][ACC_WIDTH-1:0] buf_q;
	logic [GROUP_W-1:0]              group_q;
	logic [IDX_W-1:0]                cnt_q;
	logic                            busy_q;
	logic                            xfer;
	logic                            done;
	logic signed [EXT_W-1:0]         ext;

	assign xfer = out_ch.valid && out_ch.ready;
	assign done = xfer && (cnt_q == LAST_IDX);
	assign free = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (xfer) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// lane 0 sits at the head after a load, the rest move down one per transfer
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q   <= totals;
			group_q <= group;
		end else if (xfer) begin
			for (int l = 0; l < LANES - 1; l++) begin
				buf_q[l] <= buf_q[l+1];
			end
		end
	end

	assign ext                = EXT_W'($signed(buf_q[0]));
	assign out_ch.valid       = busy_q;
	assign out_ch.dot_sum     = ext[DOT_W-1:0];
	assign out_ch.column      = COL_W'(group_q) * COL_W'(LANES) + COL_W'(cnt_q);
	assign out_ch.last_column = (cnt_q == LAST_IDX);

endmodule

@@ sv/ternary_lut_dot_product.sv @@
`timescale 1ns / 1ps
// top level: shared pair tables, accumulating lanes and result drain
//
//   channel  dir  fields
//   in_ch    in   act_0..act_3, weight_codes, column_group, last_step
//   out_ch   out  column, dot_sum, last_column
//
// one item per cycle unless a last step waits; each item is registered, then accumulated
// a last step loads all lane totals into the drain, which sends LANES results,
// one per cycle as long as out_ch.ready is high, while later items keep accumulating
// a second last step waits in the step register until the drain is free
// reset clears accumulators, step register and drain; output stalls back up into in_ch.ready
module ternary_lut_dot_product
	import tlut_pkg::*;
#(
	parameter int LANES     = LANES_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tlut_in_if.sink     in_ch,
	tlut_out_if.source  out_ch
);

	pair_tab_t                       tab01;
	pair_tab_t                       tab23;
	logic                            s1_valid_q;
	logic                            last_s1;
	logic [GROUP_W-1:0]              group_s1;
	logic                            drain_free;
	logic                            s1_go;
	logic                            in_xfer;
	lane_ctl_t                       ctl;
	logic [LANES-1:0][ACC_WIDTH-1:0] totals;

	assign s1_go       = !last_s1 || drain_free;
	assign in_ch.ready = !s1_valid_q || s1_go;
	assign in_xfer     = in_ch.valid && in_ch.ready;

	assign ctl.capture = in_xfer;
	assign ctl.accum   = s1_valid_q && s1_go;
	assign ctl.clear   = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			last_s1    <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
			last_s1    <= in_ch.valid && in_ch.last_step;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			group_s1 <= in_ch.column_group;
		end
	end

	tlut_table u_tab01 (
		.x0  (in_ch.act_0),
		.x1  (in_ch.act_1),
		.tab (tab01)
	);

	tlut_table u_tab23 (
		.x0  (in_ch.act_2),
		.x1  (in_ch.act_3),
		.tab (tab23)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		tlut_lane #(
			.ACC_WIDTH (ACC_WIDTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.code   (in_ch.weight_codes[l*BYTE_W +: BYTE_W]),
			.tab01  (tab01),
			.tab23  (tab23),
			.total  (totals[l])
		);
	end

	tlut_drain #(
		.LANES     (LANES),
		.ACC_WIDTH (ACC_WIDTH)
	) u_drain (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ctl.accum && last_s1),
		.group  (group_s1),
		.totals (totals),
		.free   (drain_free),
		.out_ch (out_ch)
	);

endmodule

@@ sv/tlut_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the ternary lut dot product, bound to the top level
module tlut_checker
	import tlut_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [COL_W-1:0]   out_column,
	input  logic [DOT_W-1:0]   out_dot_sum,
	input  logic               out_last_column
);

	// a result waiting for ready stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_column) && $stable(out_dot_sum)
		&& $stable(out_last_column))
		else $error("stalled result changed");

	// results of one group come without gaps
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last_column |=> out_valid)
		else $error("gap inside a result group");

	// the input only stalls behind a pending result group
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// columns step by one within a group
	a_column_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last_column
		|=> out_column == $past(out_column) + COL_W'(1))
		else $error("column sequence broken");

endmodule

bind ternary_lut_dot_product tlut_checker u_tlut_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_column      (out_ch.column),
	.out_dot_sum     (out_ch.dot_sum),
	.out_last_column (out_ch.last_column)
);

@@ tb/ternary_lut_dot_product_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the ternary lut dot product with a lane sum scoreboard
module ternary_lut_dot_product_tb;
	import tlut_pkg::*;

	localparam int LANES         = LANES_DEF;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic signed [ACT_W-1:0] act_0;
		logic signed [ACT_W-1:0] act_1;
		logic signed [ACT_W-1:0] act_2;
		logic signed [ACT_W-1:0] act_3;
		logic [CODE_W-1:0]       weight_codes;
		logic [GROUP_W-1:0]      column_group;
		logic                    last_step;
	} step_t;

	typedef struct {
		logic [COL_W-1:0]        column;
		logic signed [DOT_W-1:0] dot_sum;
		logic                    last_column;
	} lane_result_t;

	// running per-lane sums and the column totals still owed by the block
	class dot_scoreboard;
		logic [DOT_W-1:0] lane_sum[LANES];
		lane_result_t     column_totals_q[$];
		int               errors;

		function new();
			foreach (lane_sum[i]) lane_sum[i] = '0;
			errors = 0;
		endfunction

		// weight pair from base-3 index, unused codes give zero
		function int pair_sum(logic [NIB_W-1:0] code, int x0, int x1);
			int c;
			c = code;
			if (c >= PAIR_CODES) return 0;
			return (c / 3 - 1) * x0 + (c % 3 - 1) * x1;
		endfunction

		function void note_step(step_t s);
			logic [BYTE_W-1:0] code_byte;
			lane_result_t      r;
			int                contrib;
			for (int lane = 0; lane < LANES; lane++) begin
				code_byte = s.weight_codes[lane*BYTE_W +: BYTE_W];
				contrib = pair_sum(code_byte[NIB_W-1:0], s.act_0, s.act_1)
					+ pair_sum(code_byte[BYTE_W-1:NIB_W], s.act_2, s.act_3);
				lane_sum[lane] = lane_sum[lane] + DOT_W'(contrib);
			end
			if (!s.last_step) return;
			for (int lane = 0; lane < LANES; lane++) begin
				r.column      = COL_W'(s.column_group * LANES + lane);
				r.dot_sum     = lane_sum[lane];
				r.last_column = (lane == LANES - 1);
				column_totals_q.push_back(r);
				lane_sum[lane] = '0;
			end
		endfunction

		function void check_result(lane_result_t got);
			lane_result_t want;
			if (column_totals_q.size() == 0) begin
				$display("%0t: unexpected result column %0d dot_sum %0d last_column %0b",
					$time, got.column, got.dot_sum, got.last_column);
				errors++;
				return;
			end
			want = column_totals_q.pop_front();
			if (got.column !== want.column) begin
				$display("%0t: column expected %0d actual %0d", $time, want.column, got.column);
				errors++;
			end
			if (got.dot_sum !== want.dot_sum) begin
				$display("%0t: dot_sum of column %0d expected %0d actual %0d",
					$time, want.column, want.dot_sum, got.dot_sum);
				errors++;
			end
			if (got.last_column !== want.last_column) begin
				$display("%0t: last_column of column %0d expected %0b actual %0b",
					$time, want.column, want.last_column, got.last_column);
				errors++;
			end
		endfunction

		function int pending();
			return column_totals_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle_pct;
	int   snk_idle_pct;
	int   cycle_count = 0;

	tlut_in_if  in_ch();
	tlut_out_if out_ch();

	dot_scoreboard sb = new();

	ternary_lut_dot_product #(
		.LANES     (LANES),
		.ACC_WIDTH (ACC_WIDTH_DEF)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// watch both channels; results always come from earlier transfers
	always @(posedge clk) begin
		lane_result_t got;
		step_t        s;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.column      = out_ch.column;
				got.dot_sum     = out_ch.dot_sum;
				got.last_column = out_ch.last_column;
				sb.check_result(got);
			end
			if (in_ch.valid && in_ch.ready) begin
				s.act_0        = in_ch.act_0;
				s.act_1        = in_ch.act_1;
				s.act_2        = in_ch.act_2;
				s.act_3        = in_ch.act_3;
				s.weight_codes = in_ch.weight_codes;
				s.column_group = in_ch.column_group;
				s.last_step    = in_ch.last_step;
				sb.note_step(s);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic step_t make_step(logic signed [ACT_W-1:0] a0, logic signed [ACT_W-1:0] a1,
			logic signed [ACT_W-1:0] a2, logic signed [ACT_W-1:0] a3,
			logic [CODE_W-1:0] codes, logic [GROUP_W-1:0] group, logic last);
		step_t s;
		s.act_0        = a0;
		s.act_1        = a1;
		s.act_2        = a2;
		s.act_3        = a3;
		s.weight_codes = codes;
		s.column_group = group;
		s.last_step    = last;
		return s;
	endfunction

	function automatic logic signed [ACT_W-1:0] rand_act();
		case ($urandom_range(7))
			0: return -8'sd128;
			1: return 8'sd127;
			default: return ACT_W'($urandom_range(255));
		endcase
	endfunction

	// mostly valid base-3 codes, now and then an unused one or raw bits
	function automatic logic [CODE_W-1:0] rand_codes();
		logic [CODE_W-1:0] codes;
		if ($urandom_range(7) == 0) return {$urandom(), $urandom()};
		for (int n = 0; n < CODE_W / NIB_W; n++) begin
			if ($urandom_range(9) == 0) codes[n*NIB_W +: NIB_W] = NIB_W'($urandom_range(15, 9));
			else codes[n*NIB_W +: NIB_W] = NIB_W'($urandom_range(8));
		end
		return codes;
	endfunction

	task automatic push_step(step_t s);
		if ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		in_ch.valid        <= 1'b1;
		in_ch.act_0        <= s.act_0;
		in_ch.act_1        <= s.act_1;
		in_ch.act_2        <= s.act_2;
		in_ch.act_3        <= s.act_3;
		in_ch.weight_codes <= s.weight_codes;
		in_ch.column_group <= s.column_group;
		in_ch.last_step    <= s.last_step;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// whole dot products of random length, a few long ones
	task automatic run_dot_products(int n_items);
		int                 sent;
		int                 len;
		logic [GROUP_W-1:0] group;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
			group = GROUP_W'($urandom_range(511));
			for (int i = 0; i < len; i++) begin
				push_step(make_step(rand_act(), rand_act(), rand_act(), rand_act(),
					rand_codes(), (i == len - 1) ? group : GROUP_W'($urandom()),
					i == len - 1));
			end
			sent += len;
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] code_byte;
		arst_n             = 1'b0;
		src_idle_pct       = 30;
		snk_idle_pct       = 85;
		in_ch.valid        = 1'b0;
		in_ch.act_0        = '0;
		in_ch.act_1        = '0;
		in_ch.act_2        = '0;
		in_ch.act_3        = '0;
		in_ch.weight_codes = '0;
		in_ch.column_group = '0;
		in_ch.last_step    = 1'b0;
		out_ch.ready       = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, every nibble value in both halves of the code bytes, group ends
		push_step(make_step(8'sd127, 8'sd127, 8'sd127, 8'sd127, 64'h8888_8888_8888_8888,
			9'd0, 1'b0));
		push_step(make_step(-8'sd128, -8'sd128, -8'sd128, -8'sd128, 64'h0, 9'd0, 1'b0));
		push_step(make_step(-8'sd128, 8'sd127, -8'sd128, 8'sd127, 64'hF7E6_D5C4_B3A2_9180,
			9'd0, 1'b0));
		push_step(make_step(8'sd127, -8'sd128, 8'sd1, -8'sd1, 64'h7F6E_5D4C_3B2A_1908,
			9'd0, 1'b1));
		// single-step products, back to back last steps, then a two-step product
		push_step(make_step(8'sd85, -8'sd86, 8'sd0, -8'sd1, 64'h4444_4444_4444_4444,
			9'd511, 1'b1));
		push_step(make_step(-8'sd128, 8'sd127, -8'sd1, 8'sd0, 64'h0123_4567_89AB_CDEF,
			9'd511, 1'b1));
		push_step(make_step(-8'sd86, 8'sd85, 8'sd127, -8'sd128, {CODE_W{1'b1}},
			9'h155, 1'b0));
		push_step(make_step(8'sd1, 8'sd2, 8'sd3, 8'sd4, 64'h2615_0837_4826_1503,
			9'h0AA, 1'b1));
		for (int c = 0; c < PAIR_CODES; c++) begin
			code_byte = {NIB_W'(c), NIB_W'(c)};
			push_step(make_step(rand_act(), rand_act(), rand_act(), rand_act(),
				{8{code_byte}}, GROUP_W'(c), c == PAIR_CODES - 1));
		end

		run_dot_products(90);
		// hold off until the drain is empty
		wait_drained();

		src_idle_pct = 85;
		snk_idle_pct = 30;
		run_dot_products(90);
		wait_drained();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_dot_products(90);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			$display("%0t: %0d column totals never arrived", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/tlut_pkg.sv
sv/tlut_if.sv
sv/tlut_table.sv
sv/tlut_lane.sv
sv/tlut_drain.sv
sv/ternary_lut_dot_product.sv
sv/tlut_checker.sv
tb/ternary_lut_dot_product_tb.sv
